// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. They compile away when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg
// Widths, character codes and state encoding of the integer to decimal
// text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

  // Width of the two's complement input value.
  localparam int VALUE_BITS = 32;

  // Decimal digits needed for 2^VALUE_BITS - 1 (1233/4096 approximates log10 2).
  localparam int DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCD_W  = DIGITS * 4;
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int DIG_W  = $clog2(DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef logic signed [VALUE_BITS-1:0] number_t;
  typedef logic [7:0]                   char_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

endpackage

// ===== hw/rtl/sitda_if.sv =====
// ----------------------------------------------------------------------------
// sitda_num_if / sitda_char_if
// Valid/ready channels: one carries an input number, the other one text
// character with its end-of-text flag.
// ----------------------------------------------------------------------------
interface sitda_num_if;
  import sitda_pkg::*;

  logic    valid;
  logic    ready;
  number_t number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface sitda_char_if;
  import sitda_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_code;
  logic  last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== hw/rtl/signed_int_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a signed integer into its decimal ASCII text, one character per
// output item, most significant first, with the final character flagged.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload               Notes
//   in_if     sink       number (signed)       one number per item
//   out_if    source     char_code, last_char  one character per item
//
// A number is accepted only while the converter is idle. The magnitude is
// then run through a shift-and-add-3 binary to BCD unit, one bit per cycle.
// Emission then walks the BCD digits from the top, one digit position per
// cycle while the output register can take a character: leading zeros are
// dropped, a '-' is sent first for negative values. Reset is synchronous
// and active low; it returns the sequencer to idle and empties the output
// register. A stalled output register holds the emit sequence where it is;
// a new number is taken while the last character of the previous one still
// waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_top (
  input  logic        clk,
  input  logic        rst_n,
  sitda_num_if.sink   in_if,
  sitda_char_if.source out_if
);
  import sitda_pkg::*;

  state_t                  state_r, state_nxt;
  logic [VALUE_BITS-1:0]   mag_r, mag_nxt;
  logic [BCD_W-1:0]        bcd_r, bcd_nxt;
  logic [BCD_W-1:0]        bcd_adj;
  logic [CNT_W-1:0]        bit_cnt_r, bit_cnt_nxt;
  logic [DIG_W-1:0]        left_r, left_nxt;
  logic                    neg_r, neg_nxt;
  logic                    started_r, started_nxt;

  logic                    out_valid_r, out_valid_nxt;
  char_t                   out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [VALUE_BITS-1:0]   num_u;
  logic [3:0]              top_digit;
  logic                    load_ok;
  logic                    accept;

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign num_u       = VALUE_BITS'(in_if.number);
  assign load_ok     = !out_valid_r || out_if.ready;
  assign top_digit   = bcd_r[BCD_W-1 -: 4];

  // Add-3 correction on every BCD digit before the shift. The digits are
  // independent of each other, so this is one layer of small adders.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    left_nxt      = left_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_if.ready;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // The unsigned negation also gives the right magnitude for the
          // most negative value.
          neg_nxt     = num_u[VALUE_BITS-1];
          mag_nxt     = num_u[VALUE_BITS-1] ? (~num_u + 1'b1) : num_u;
          bcd_nxt     = '0;
          bit_cnt_nxt = CNT_W'(VALUE_BITS);
          left_nxt    = DIG_W'(DIGITS);
          started_nxt = 1'b0;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
        mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == CNT_W'(1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (neg_r) begin
          if (load_ok) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CHAR_MINUS;
            out_last_nxt  = 1'b0;
            neg_nxt       = 1'b0;
          end
        end else if (!started_r && top_digit == 4'd0 && left_r != DIG_W'(1)) begin
          // Leading zero: drop it without touching the output register.
          bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
          left_nxt = left_r - 1'b1;
        end else if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {4'd0, top_digit};
          out_last_nxt  = (left_r == DIG_W'(1));
          started_nxt   = 1'b1;
          bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
          left_nxt      = left_r - 1'b1;
          if (left_r == DIG_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      started_r   <= 1'b0;
      bit_cnt_r   <= '0;
      left_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
      started_r   <= started_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      left_r      <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.char_code = out_char_r;
  assign out_if.last_char = out_last_r;

  // A text never ends with the sign character.
  `ASSERT_IMP(a_last_is_digit, clk, rst_n, out_if.valid && out_if.last_char, out_if.char_code != CHAR_MINUS)
  // An accepted number starts a full-length conversion.
  `ASSERT_NXT(a_accept_conv, clk, rst_n, accept, (state_r == S_CONV) && (bit_cnt_r == CNT_W'(VALUE_BITS)))
  // The final conversion step always hands over to emission.
  `ASSERT_NXT(a_conv_to_emit, clk, rst_n, (state_r == S_CONV) && (bit_cnt_r == CNT_W'(1)), state_r == S_EMIT)
  // Emission never runs out of digit positions.
  `ASSERT_IMP(a_emit_left, clk, rst_n, state_r == S_EMIT, left_r != DIG_W'(0))

endmodule
